FILE: rtl/srap_pkg.sv
// Package for the STUN response attribute parser.
// Holds the shared constants, the queue item type and the code enums.
// No dependencies; every other file imports it.
`default_nettype none

package srap_pkg;

    localparam int MAX_PAYLOAD_BYTES_DEF = 1024;
    localparam int HDR_BYTES             = 20;
    localparam int ADDR_VALUE_BYTES      = 8;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FLAGS_W  = 3;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Window of value bytes that holds port and address.
    localparam int SHIFT_W = 48;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam int FLAG_PLAIN = 0;
    localparam int FLAG_XOR   = 1;
    localparam int FLAG_ALT   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COOKIE     = 2'd0,
        CFG_PLAIN_TYPE = 2'd1,
        CFG_XOR_TYPE   = 2'd2,
        CFG_ALT_TYPE   = 2'd3
    } srap_cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_SHORT_HDR = 2'd1,
        ST_TRUNC_HDR = 2'd2,
        ST_OVERRUN   = 2'd3
    } srap_status_t;

    // What the back end does with a queued byte.
    typedef enum logic [2:0] {
        ROLE_NONE,
        ROLE_TYPE_HI,
        ROLE_TYPE_LO,
        ROLE_VALUE,
        ROLE_VALUE_TAKE
    } srap_role_t;

    typedef struct packed {
        srap_role_t         role;
        logic [BYTE_W-1:0]  data;
        logic               last;
        srap_status_t       status;
    } srap_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] cookie;
        logic [WORD_W-1:0] plain_type;
        logic [WORD_W-1:0] xor_type;
        logic [WORD_W-1:0] alt_type;
    } srap_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/srap_if.sv
// Stream interfaces of the STUN response attribute parser.
// srap_in_if carries payload bytes, srap_out_if carries results; uses srap_pkg.
`default_nettype none

interface srap_in_if;
    import srap_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_byte;

    modport source (output valid, output payload_byte, output last_byte, input ready);
    modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface srap_out_if;
    import srap_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FLAGS_W-1:0]  found_flags;
    logic [WORD_W-1:0]   mapped_port;
    logic [ADDR_W-1:0]   mapped_addr;

    modport source (output valid, output status, output found_flags,
                    output mapped_port, output mapped_addr, input ready);
    modport sink   (input valid, input status, input found_flags,
                    input mapped_port, input mapped_addr, output ready);
endinterface

`default_nettype wire

FILE: rtl/stun_response_attribute_parser_core.sv
// STUN response attribute parser, top level.
// The pkt channel takes one UDP payload byte per item with last_byte on the
// final byte of a reply. The result channel gives one item per reply: status,
// found flags and the extracted port and IPv4 address.
// The cfg port writes the cookie and the three attribute type codes by index;
// write it only while no reply is in flight.
// Takes one byte per cycle while pkt.ready is high. The front end frames
// header and attributes, a two-entry queue feeds the back end, which matches
// types and holds the address. The final byte is written into the queue and,
// once the back end pops it, sets the result register behind result.valid.
// When the result is not taken, the back end stops at the next final byte,
// the queue fills and pkt.ready drops; bytes before that keep flowing.
// Reset clears all framing state, empties the queue and the result, and loads
// the cookie 0x2112A442 and the type codes 0x0001, 0x0020 and 0x8020.
// Bytes past MAX_PAYLOAD_BYTES are dropped, but their last flag ends the reply.
// Depends on srap_pkg, srap_if, srap_front, srap_fifo and srap_back.
`default_nettype none

module stun_response_attribute_parser_core #(
    parameter int MAX_PAYLOAD_BYTES = srap_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    srap_in_if.sink                            pkt,
    srap_out_if.source                         result,
    input  wire logic                          cfg_we,
    input  wire logic [srap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [srap_pkg::CFG_W-1:0]    cfg_data
);
    import srap_pkg::*;

    srap_cfg_t  cfg_reg;
    srap_item_t q_item;
    srap_item_t q_head;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cookie     <= 32'h2112A442;
            cfg_reg.plain_type <= 16'h0001;
            cfg_reg.xor_type   <= 16'h0020;
            cfg_reg.alt_type   <= 16'h8020;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COOKIE:     cfg_reg.cookie     <= cfg_data;
                CFG_PLAIN_TYPE: cfg_reg.plain_type <= cfg_data[WORD_W-1:0];
                CFG_XOR_TYPE:   cfg_reg.xor_type   <= cfg_data[WORD_W-1:0];
                CFG_ALT_TYPE:   cfg_reg.alt_type   <= cfg_data[WORD_W-1:0];
                default:        ;
            endcase
        end
    end

    srap_front #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt    (pkt),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_item)
    );

    srap_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    srap_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result)
    );

`ifndef ASSERT_OFF
    // Found flags are only reported on a clean parse.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != ST_OK)) |-> (result.found_flags == '0))
        else $error("found flags set on an error status");

    // A short header never carries an extracted address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == ST_SHORT_HDR))
            |-> ((result.mapped_addr == '0) && (result.mapped_port == '0)))
        else $error("address reported with a short header");

    // A final item leaves the queue only when the result register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.last) |-> (!result.valid || result.ready))
        else $error("result overwritten before it was taken");

    // The front end only stalls when the queue holds items.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!pkt.ready) |-> (!q_empty))
        else $error("input stalled with an empty queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/srap_front.sv
// Front end: accepts payload bytes, tracks header and attribute framing,
// tags each byte with a role and computes the packet status on the last byte.
// Depends on srap_pkg and srap_in_if.
`default_nettype none

module srap_front #(
    parameter int MAX_PAYLOAD_BYTES = srap_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    srap_in_if.sink                 pkt,
    input  wire logic               q_full,
    output logic                    q_push,
    output srap_pkg::srap_item_t    q_item
);
    import srap_pkg::*;

    localparam int IDX_W = $clog2(MAX_PAYLOAD_BYTES + 1);

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] adv_reg, adv_next;
    logic [WORD_W-1:0] apos_reg, apos_next;
    logic [WORD_W-1:0] alen_reg, alen_next;

    logic [WORD_W-1:0] off;
    logic              in_range;
    logic              is_body;
    srap_role_t        role;
    srap_status_t      status;
    logic [BYTE_W-1:0] b;

    assign pkt.ready = !q_full;
    assign q_push    = pkt.valid && pkt.ready;
    assign b         = pkt.payload_byte;

    always_comb
    begin
        off       = WORD_W'(idx_reg) - WORD_W'(HDR_BYTES);
        in_range  = idx_reg < IDX_W'(MAX_PAYLOAD_BYTES);
        is_body   = in_range && (idx_reg >= IDX_W'(HDR_BYTES)) && (off < adv_reg);
        idx_next  = idx_reg;
        adv_next  = adv_reg;
        apos_next = apos_reg;
        alen_next = alen_reg;
        role      = ROLE_NONE;

        if (in_range)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == IDX_W'(2))
                adv_next = {b, 8'h00};
            else if (idx_reg == IDX_W'(3))
                adv_next = {adv_reg[15:8], b};
        end

        if (is_body)
        begin
            if (apos_reg == 16'd0)
            begin
                role      = ROLE_TYPE_HI;
                apos_next = 16'd1;
            end
            else if (apos_reg == 16'd1)
            begin
                role      = ROLE_TYPE_LO;
                apos_next = 16'd2;
            end
            else if (apos_reg == 16'd2)
            begin
                alen_next = {b, 8'h00};
                apos_next = 16'd3;
            end
            else if (apos_reg == 16'd3)
            begin
                alen_next = {alen_reg[15:8], b};
                // An empty value closes the attribute at its header.
                apos_next = (alen_next == 16'd0) ? 16'd0 : 16'd4;
            end
            else if ({1'b0, apos_reg} == ({1'b0, alen_reg} + 17'd3))
            begin
                role      = (alen_reg == 16'(ADDR_VALUE_BYTES)) ? ROLE_VALUE_TAKE
                                                                 : ROLE_VALUE;
                apos_next = 16'd0;
            end
            else
            begin
                role      = ROLE_VALUE;
                apos_next = apos_reg + 16'd1;
            end
        end

        // The bytes into the pending attribute are what is left unparsed.
        if (idx_next < IDX_W'(HDR_BYTES))
            status = ST_SHORT_HDR;
        else if (apos_next == 16'd0)
            status = ST_OK;
        else if (apos_next < 16'd4)
            status = ST_TRUNC_HDR;
        else
            status = ST_OVERRUN;

        if (pkt.last_byte)
        begin
            idx_next  = '0;
            adv_next  = '0;
            apos_next = '0;
            alen_next = '0;
        end

        q_item.role   = role;
        q_item.data   = b;
        q_item.last   = pkt.last_byte;
        q_item.status = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            adv_reg  <= '0;
            apos_reg <= '0;
            alen_reg <= '0;
        end
        else if (q_push)
        begin
            idx_reg  <= idx_next;
            adv_reg  <= adv_next;
            apos_reg <= apos_next;
            alen_reg <= alen_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/srap_fifo.sv
// Two-entry queue of tagged bytes between the front and back ends.
// Depends on srap_pkg.
`default_nettype none

module srap_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  srap_pkg::srap_item_t    push_item,
    input  wire logic               pop,
    output srap_pkg::srap_item_t    head,
    output logic                    full,
    output logic                    empty
);
    import srap_pkg::*;

    srap_item_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

FILE: rtl/srap_back.sv
// Back end: builds attribute type and value from tagged bytes, matches the
// configured types, holds the extracted address and drives the result register.
// Depends on srap_pkg and srap_out_if.
`default_nettype none

module srap_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  srap_pkg::srap_cfg_t     cfg,
    input  srap_pkg::srap_item_t    head,
    input  wire logic               q_empty,
    output logic                    q_pop,
    srap_out_if.source              result
);
    import srap_pkg::*;

    logic [WORD_W-1:0]  type_reg, type_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [FLAGS_W-1:0] flags_reg, flags_next;
    logic [WORD_W-1:0]  port_reg, port_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;

    logic                valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [FLAGS_W-1:0]  found_reg;
    logic [WORD_W-1:0]   oport_reg;
    logic [ADDR_W-1:0]   oaddr_reg;

    // A last item needs the result register free or draining this cycle.
    assign q_pop = !q_empty && (!head.last || !valid_reg || result.ready);

    always_comb
    begin
        type_next  = type_reg;
        shift_next = shift_reg;
        flags_next = flags_reg;
        port_next  = port_reg;
        addr_next  = addr_reg;
        unique case (head.role)
            ROLE_NONE:
                ;
            ROLE_TYPE_HI:
                type_next[15:8] = head.data;
            ROLE_TYPE_LO:
                type_next[7:0] = head.data;
            ROLE_VALUE:
                shift_next = {shift_reg[SHIFT_W-BYTE_W-1:0], head.data};
            ROLE_VALUE_TAKE:
            begin
                shift_next = {shift_reg[SHIFT_W-BYTE_W-1:0], head.data};
                // Plain wins over xor on equal codes, even when it is skipped.
                if (type_reg == cfg.plain_type)
                begin
                    if (addr_reg == '0)
                    begin
                        port_next = shift_next[47:32];
                        addr_next = shift_next[31:0];
                        flags_next[FLAG_PLAIN] = 1'b1;
                    end
                end
                else if ((type_reg == cfg.xor_type) || (type_reg == cfg.alt_type))
                begin
                    port_next = shift_next[47:32] ^ cfg.cookie[31:16];
                    addr_next = shift_next[31:0] ^ cfg.cookie;
                    if (type_reg == cfg.xor_type)
                        flags_next[FLAG_XOR] = 1'b1;
                    else
                        flags_next[FLAG_ALT] = 1'b1;
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            port_reg  <= '0;
            addr_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (head.last)
                begin
                    flags_reg <= '0;
                    port_reg  <= '0;
                    addr_reg  <= '0;
                end
                else
                begin
                    flags_reg <= flags_next;
                    port_reg  <= port_next;
                    addr_reg  <= addr_next;
                end
            end
            if (q_pop && head.last)
                valid_reg <= 1'b1;
            else if (result.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            type_reg  <= type_next;
            shift_reg <= shift_next;
        end
        if (q_pop && head.last)
        begin
            status_reg <= head.status;
            found_reg  <= (head.status == ST_OK) ? flags_next : '0;
            oport_reg  <= port_next;
            oaddr_reg  <= addr_next;
        end
    end

    assign result.valid       = valid_reg;
    assign result.status      = status_reg;
    assign result.found_flags = found_reg;
    assign result.mapped_port = oport_reg;
    assign result.mapped_addr = oaddr_reg;

endmodule

`default_nettype wire
